// ===== hdl/ulfd_pkg.sv =====
// Shared types and constants of the list engine.
package ulfd_pkg;

    localparam int DEPTH_DEF       = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int ACTION_W   = 2;
    localparam int IN_VALUE_W = 32;
    localparam int IN_DATA_W  = 32;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 5;
    localparam int COUNT_W    = 6;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_FIND   = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } t_state;

    // Per-cell load control: wr takes the new value, shift takes the right neighbor.
    typedef struct packed {
        logic wr;
        logic shift;
    } t_cell_ctl;

endpackage

// ===== hdl/ulfd_cell.sv =====
// One storage cell of the list: holds an entry, compares it, shifts from its neighbor.
module ulfd_cell #(
    parameter int VALUE_WIDTH = ulfd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  ulfd_pkg::t_cell_ctl    i_ctl,
    input  logic                   i_valid,
    input  logic [VALUE_WIDTH-1:0] i_key,
    input  logic [VALUE_WIDTH-1:0] i_wdata,
    input  logic [VALUE_WIDTH-1:0] i_next,
    output logic [VALUE_WIDTH-1:0] o_entry,
    output logic                   o_hit
);
    import ulfd_pkg::*;

    logic [VALUE_WIDTH-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_entry <= i_wdata;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = i_valid && (r_entry == i_key);

endmodule

// ===== hdl/ulfd_ctrl.sv =====
// Sequencer of the list: count, match priority, cell controls and result register.
module ulfd_ctrl #(
    parameter int DEPTH       = ulfd_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = ulfd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [ulfd_pkg::ACTION_W-1:0]     i_action,
    input  logic [VALUE_WIDTH-1:0]            i_key,
    input  logic [DEPTH-1:0]                  i_hit,
    output logic [$clog2(DEPTH+1)-1:0]        o_cnt,
    output logic [VALUE_WIDTH-1:0]            o_wdata,
    output ulfd_pkg::t_cell_ctl               o_ctl [DEPTH],
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [ulfd_pkg::STATUS_W-1:0]     o_status,
    output logic [ulfd_pkg::POS_W-1:0]        o_position,
    output logic [ulfd_pkg::COUNT_W-1:0]      o_count
);
    import ulfd_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [DEPTH-1:0] ALL_ONES = '1;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [ACTION_W-1:0]    r_act;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [DEPTH-1:0]       r_hit;
    logic                   r_m_tvalid, n_m_tvalid;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [POS_W-1:0]       r_position, n_position;
    logic [COUNT_W-1:0]     r_count, n_count;

    logic [DEPTH-1:0]       w_incl;
    logic [DEPTH-1:0]       w_first;
    logic [IDX_W-1:0]       w_idx;
    logic                   w_any;
    logic                   w_accept;
    logic                   w_go;
    logic                   w_full;

    // Prefix of matches: w_incl[i] is set when any match sits at or below cell i.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_incl[i] = |(r_hit & (ALL_ONES >> (DEPTH - 1 - i)));
        end
        w_first[0] = r_hit[0];
        for (int i = 1; i < DEPTH; i++) begin
            w_first[i] = r_hit[i] & ~w_incl[i-1];
        end
        w_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_idx = w_idx | ({IDX_W{w_first[i]}} & IDX_W'(i));
        end
        w_any = |r_hit;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_go       = (r_state == S_APPLY) && (!r_m_tvalid || i_m_tready);
    assign w_full     = (r_cnt >= CNT_W'(DEPTH));

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        n_status   = r_status;
        n_position = r_position;
        n_count    = r_count;
        for (int i = 0; i < DEPTH; i++) begin
            o_ctl[i] = '0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (w_go) begin
                    n_state    = S_IDLE;
                    n_m_tvalid = 1'b1;
                    n_status   = ST_MISS;
                    n_position = '0;
                    case (t_action'(r_act))
                        ACT_INSERT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    o_ctl[i].wr = (r_cnt == CNT_W'(i));
                                end
                                n_position = POS_W'(r_cnt);
                                n_cnt      = r_cnt + 1'b1;
                                n_status   = ST_DONE;
                            end
                        end
                        ACT_DELETE: begin
                            if (w_any) begin
                                // close the gap: every cell from the match up takes its neighbor
                                for (int i = 0; i < DEPTH; i++) begin
                                    o_ctl[i].shift = w_incl[i];
                                end
                                n_position = POS_W'(w_idx);
                                n_cnt      = r_cnt - 1'b1;
                                n_status   = ST_DONE;
                            end
                        end
                        ACT_FIND: begin
                            if (w_any) begin
                                n_position = POS_W'(w_idx);
                                n_status   = ST_DONE;
                            end
                        end
                        default: begin
                            n_status = ST_MISS;
                        end
                    endcase
                    n_count = COUNT_W'(n_cnt);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act   <= i_action;
            r_value <= i_key;
            r_hit   <= i_hit;
        end
        r_status   <= n_status;
        r_position <= n_position;
        r_count    <= n_count;
    end

    assign o_cnt      = r_cnt;
    assign o_wdata    = r_value;
    assign o_m_tvalid = r_m_tvalid;
    assign o_status   = r_status;
    assign o_position = r_position;
    assign o_count    = r_count;

endmodule

// ===== hdl/unordered_list_find_delete.sv =====
// Top level of the list engine: a row of storage cells under one sequencer.
//
//  channel | dir | signals                  | contents (low bits first)
//  --------+-----+--------------------------+------------------------------------
//  s       | in  | tvalid tready tdata tuser| tdata: value[31:0]; tuser: action[1:0]
//  m       | out | tvalid tready tdata tuser| tdata: position[4:0], count[10:5]
//          |     |                          | tuser: status[1:0]
//
// A transaction has an accept step to compare the value against all cells and
// register the match vector, and an apply step to resolve the first match, shift or
// load the cells and load the result register. The result register lets the next
// transaction be taken while the last result waits; a result still held stalls the
// apply step. Reset (synchronous, active low) clears the count and the result valid;
// the cells hold no reset value and only cells below the count are ever compared.
module unordered_list_find_delete #(
    parameter int DEPTH       = ulfd_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = ulfd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [ulfd_pkg::IN_DATA_W-1:0]    i_s_tdata,  // value[31:0]
    input  logic [ulfd_pkg::ACTION_W-1:0]     i_s_tuser,  // action[1:0]
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [ulfd_pkg::OUT_DATA_W-1:0]   o_m_tdata,  // position[4:0], count[10:5]
    output logic [ulfd_pkg::STATUS_W-1:0]     o_m_tuser   // status[1:0]
);
    import ulfd_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [VALUE_WIDTH-1:0] w_key;
    logic [VALUE_WIDTH-1:0] w_wdata;
    logic [VALUE_WIDTH-1:0] w_entry [DEPTH];
    logic [VALUE_WIDTH-1:0] w_next  [DEPTH];
    logic [DEPTH-1:0]       w_hit;
    logic [DEPTH-1:0]       w_valid;
    logic [CNT_W-1:0]       w_cnt;
    t_cell_ctl              w_ctl   [DEPTH];
    logic [POS_W-1:0]       w_position;
    logic [COUNT_W-1:0]     w_count;

    assign w_key = VALUE_WIDTH'(i_s_tdata[IN_VALUE_W-1:0]);

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign w_valid[i] = (CNT_W'(i) < w_cnt);
        if (i == DEPTH - 1) begin : g_last
            assign w_next[i] = w_entry[i];
        end else begin : g_mid
            assign w_next[i] = w_entry[i+1];
        end

        ulfd_cell #(
            .VALUE_WIDTH(VALUE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[i]),
            .i_valid (w_valid[i]),
            .i_key   (w_key),
            .i_wdata (w_wdata),
            .i_next  (w_next[i]),
            .o_entry (w_entry[i]),
            .o_hit   (w_hit[i])
        );
    end

    ulfd_ctrl #(
        .DEPTH      (DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_action   (i_s_tuser),
        .i_key      (w_key),
        .i_hit      (w_hit),
        .o_cnt      (w_cnt),
        .o_wdata    (w_wdata),
        .o_ctl      (w_ctl),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_status   (o_m_tuser),
        .o_position (w_position),
        .o_count    (w_count)
    );

    assign o_m_tdata = OUT_DATA_W'({w_count, w_position});

endmodule

// ===== hdl/ulfd_chk.sv =====
// Port-level checks of the list engine, bound to the top level.
module ulfd_chk #(
    parameter int DEPTH = ulfd_pkg::DEPTH_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [ulfd_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic [ulfd_pkg::STATUS_W-1:0]   o_m_tuser
);
    import ulfd_pkg::*;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_FULL) |-> (o_m_tdata[10:5] == FULL_COUNT))
        else $error("full status without full count");

    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_MISS) |-> (o_m_tdata[4:0] == '0))
        else $error("miss status with nonzero position");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind unordered_list_find_delete ulfd_chk #(
    .DEPTH(DEPTH)
) u_ulfd_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
